### design/gtdd_pkg.sv
`default_nettype none
package gtdd_pkg;

   // Fraction bits of the Q0.16 gains; the PD sum is scaled down by this many bits.
   localparam int GainFracBits = 16;

   // Width of the PD accumulator: a 17x16 product plus a 17x17 product.
   localparam int AccWidth = 35;

   // Entries in the queue between the front and the back.
   localparam int QueueDepth = 2;

   // Input opcodes.
   localparam logic [1:0] OpStart = 2'd0;
   localparam logic [1:0] OpGyro  = 2'd1;
   localparam logic [1:0] OpStop  = 2'd2;

   // Run modes, which are also the direction codes of a result.
   localparam logic [1:0] ModeOff = 2'd0;
   localparam logic [1:0] ModeFwd = 2'd1;
   localparam logic [1:0] ModeBwd = 2'd2;

   // Command kinds that the front hands to the back.
   localparam logic [1:0] KindHold  = 2'd0;
   localparam logic [1:0] KindStart = 2'd1;
   localparam logic [1:0] KindStop  = 2'd2;
   localparam logic [1:0] KindTrim  = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] RegGainP    = 3'd0;
   localparam logic [2:0] RegGainD    = 3'd1;
   localparam logic [2:0] RegRangeUp  = 3'd2;
   localparam logic [2:0] RegRangeDn  = 3'd3;
   localparam logic [2:0] RegCeiling  = 3'd4;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_d;
      logic [14:0] range_above;
      logic [14:0] range_below;
      logic [15:0] pulse_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         mode;
      logic [14:0]        base_left;
      logic [14:0]        base_right;
      logic signed [15:0] correction;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic has_entry;
   } queue_status_type;

endpackage
`default_nettype wire

### design/gyro_trim_differential_drive.sv
`default_nettype none
// A transferred request is written into the queue; the back pops it and registers
// the response, which waits in the output register until it is transferred.
// Throughput: one request per cycle while the queue has room; the front computes the PD
// correction in the accept cycle and the back applies it on pop; no loop limits the rate.
// Reset is synchronous and active high; it restores the default gains, ranges and
// ceiling, stops the drive, zeroes levels, baselines and error, and empties the queue.
module gyro_trim_differential_drive (
   input  wire logic        clock,
   input  wire logic        reset,

   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] backward, [15:1] baseline_left, [30:16] baseline_right,
   // [46:31] gyro_rate, [47] zero.
   input  wire logic [47:0] req_tdata,
   // [1:0] opcode.
   input  wire logic [1:0]  req_tuser,

   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [16:0] pulse_left, [33:17] pulse_right, [35:34] direction,
   // [51:36] correction, [55:52] zero.
   output logic [55:0]      rsp_tdata,

   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   gtdd_pkg::cfg_type          cfg;
   gtdd_pkg::cmd_type          front_cmd;
   gtdd_pkg::cmd_type          back_cmd;
   gtdd_pkg::queue_status_type queue_status;

   logic               req_accept;
   logic               back_pop;
   logic signed [16:0] pulse_left;
   logic signed [16:0] pulse_right;
   logic [1:0]         direction;
   logic signed [15:0] correction;

   // Configuration writes are taken whenever reset is low.
   assign csr_ready = !reset;

   // The front only needs room in the queue; a response waiting on the
   // output does not stop new requests until the queue fills. Nothing is
   // taken while reset is high.
   assign req_tready = !reset && !queue_status.full;
   assign req_accept = req_tvalid && req_tready;

   gtdd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .write (csr_valid && csr_ready),
      .index (csr_index),
      .data  (csr_data),
      .cfg   (cfg)
   );

   // The front tracks the run mode and the previous error, so it can decide
   // what each request means and compute its correction right away.
   gtdd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .opcode         (req_tuser),
      .backward       (req_tdata[0]),
      .baseline_left  (req_tdata[15:1]),
      .baseline_right (req_tdata[30:16]),
      .gyro_rate      ($signed(req_tdata[46:31])),
      .cfg            (cfg),
      .cmd            (front_cmd)
   );

   gtdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .pop       (back_pop),
      .pop_data  (back_cmd),
      .status    (queue_status)
   );

   // The back owns the pulse levels and baselines and the output register.
   gtdd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .has_cmd         (queue_status.has_entry),
      .cmd             (back_cmd),
      .cfg             (cfg),
      .pop             (back_pop),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_pulse_left  (pulse_left),
      .rsp_pulse_right (pulse_right),
      .rsp_direction   (direction),
      .rsp_correction  (correction)
   );

   assign rsp_tdata = {4'b0000, correction, direction, pulse_right, pulse_left};

endmodule
`default_nettype wire

### design/gtdd_csr.sv
`default_nettype none
module gtdd_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              write,
   input  wire logic [2:0]        index,
   input  wire logic [15:0]       data,
   output gtdd_pkg::cfg_type      cfg
);

   gtdd_pkg::cfg_type cfg_ff;
   gtdd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            gtdd_pkg::RegGainP:   cfg_in.gain_p        = data;
            gtdd_pkg::RegGainD:   cfg_in.gain_d        = data;
            gtdd_pkg::RegRangeUp: cfg_in.range_above   = data[14:0];
            gtdd_pkg::RegRangeDn: cfg_in.range_below   = data[14:0];
            gtdd_pkg::RegCeiling: cfg_in.pulse_ceiling = data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p        <= 16'd459;
         cfg_ff.gain_d        <= 16'd66;
         cfg_ff.range_above   <= 15'd2000;
         cfg_ff.range_below   <= 15'd2000;
         cfg_ff.pulse_ceiling <= 16'd23999;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### design/gtdd_front.sv
`default_nettype none
module gtdd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [1:0]         opcode,
   input  wire logic               backward,
   input  wire logic [14:0]        baseline_left,
   input  wire logic [14:0]        baseline_right,
   input  wire logic signed [15:0] gyro_rate,
   input  wire gtdd_pkg::cfg_type  cfg,
   output gtdd_pkg::cmd_type       cmd
);

   localparam int AccW = gtdd_pkg::AccWidth;
   localparam int Frac = gtdd_pkg::GainFracBits;

   logic [1:0]          mode_ff;
   logic [1:0]          mode_in;
   logic signed [15:0]  prev_err_ff;
   logic signed [15:0]  prev_err_in;

   logic signed [16:0]     err_diff;
   logic signed [32:0]     p_prod;
   logic signed [33:0]     d_prod;
   logic signed [AccW-1:0] acc;
   logic signed [AccW-1:0] quot_floor;
   logic signed [AccW-1:0] quot;
   logic                   quot_fits;
   logic signed [15:0]     corr;

   // PD term: gains are unsigned, so each gets a zero sign bit first.
   assign err_diff = 17'(prev_err_ff) - 17'(gyro_rate);
   assign p_prod   = $signed({1'b0, cfg.gain_p}) * gyro_rate;
   assign d_prod   = $signed({1'b0, cfg.gain_d}) * err_diff;
   assign acc      = AccW'(p_prod) + AccW'(d_prod);

   // Arithmetic shift floors; add one back for a negative sum with a fraction
   // so the quotient rounds toward zero.
   assign quot_floor = acc >>> Frac;
   assign quot = (acc[AccW-1] && (acc[Frac-1:0] != '0)) ? quot_floor + AccW'(1) : quot_floor;

   assign quot_fits = (quot[AccW-1:15] == '0) || (quot[AccW-1:15] == '1);
   assign corr = quot_fits ? quot[15:0] : (quot[AccW-1] ? 16'sh8000 : 16'sh7FFF);

   always_comb begin
      mode_in        = mode_ff;
      prev_err_in    = prev_err_ff;
      cmd.kind       = gtdd_pkg::KindHold;
      cmd.base_left  = baseline_left;
      cmd.base_right = baseline_right;
      cmd.correction = '0;
      case (opcode)
         gtdd_pkg::OpStart: begin
            cmd.kind = gtdd_pkg::KindStart;
            mode_in  = backward ? gtdd_pkg::ModeBwd : gtdd_pkg::ModeFwd;
         end
         gtdd_pkg::OpStop: begin
            cmd.kind = gtdd_pkg::KindStop;
            mode_in  = gtdd_pkg::ModeOff;
         end
         gtdd_pkg::OpGyro: begin
            if (mode_ff != gtdd_pkg::ModeOff) begin
               cmd.kind       = gtdd_pkg::KindTrim;
               cmd.correction = corr;
               prev_err_in    = gyro_rate;
            end
         end
         default: cmd.kind = gtdd_pkg::KindHold;
      endcase
      cmd.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= gtdd_pkg::ModeOff;
         prev_err_ff <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         prev_err_ff <= prev_err_in;
      end
   end

endmodule
`default_nettype wire

### design/gtdd_queue.sv
`default_nettype none
module gtdd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire gtdd_pkg::cmd_type     push_data,
   input  wire logic                  pop,
   output gtdd_pkg::cmd_type          pop_data,
   output gtdd_pkg::queue_status_type status
);

   localparam int Depth = gtdd_pkg::QueueDepth;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   gtdd_pkg::cmd_type slot_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   assign status.full      = (count_ff == CntW'(Depth));
   assign status.has_entry = (count_ff != '0);
   assign pop_data         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### design/gtdd_back.sv
`default_nettype none
module gtdd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               has_cmd,
   input  wire gtdd_pkg::cmd_type  cmd,
   input  wire gtdd_pkg::cfg_type  cfg,
   output logic                    pop,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic signed [16:0]      rsp_pulse_left,
   output logic signed [16:0]      rsp_pulse_right,
   output logic [1:0]              rsp_direction,
   output logic signed [15:0]      rsp_correction
);

   logic signed [17:0] level_left_ff;
   logic signed [17:0] level_left_in;
   logic signed [17:0] level_right_ff;
   logic signed [17:0] level_right_in;
   logic [14:0]        base_left_ff;
   logic [14:0]        base_left_in;
   logic [14:0]        base_right_ff;
   logic [14:0]        base_right_in;

   logic               rsp_valid_ff;
   logic signed [16:0] rsp_left_ff;
   logic signed [16:0] rsp_right_ff;
   logic [1:0]         rsp_dir_ff;
   logic signed [15:0] rsp_corr_ff;

   logic signed [18:0] corr_ext;
   logic signed [18:0] sum_left;
   logic signed [18:0] sum_right;
   logic               go_back;

   // Saturate at the ceiling first, then hold the side inside its window.
   function automatic logic signed [17:0] clamp_side(
      input logic signed [18:0] v,
      input logic [14:0]        base,
      input gtdd_pkg::cfg_type  c
   );
      logic signed [18:0] ceil_s;
      logic signed [18:0] hi;
      logic signed [18:0] lo;
      logic signed [18:0] r;
      ceil_s = $signed({3'b000, c.pulse_ceiling});
      hi     = $signed({4'b0000, base}) + $signed({4'b0000, c.range_above});
      lo     = $signed({4'b0000, base}) - $signed({4'b0000, c.range_below});
      if (v > ceil_s) begin
         r = ceil_s;
      end else if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[17:0];
   endfunction

   assign pop      = has_cmd && (!rsp_valid_ff || rsp_ready);
   assign go_back  = (cmd.mode == gtdd_pkg::ModeBwd);
   assign corr_ext = 19'(cmd.correction);
   assign sum_left  = 19'(level_left_ff)  + (go_back ? -corr_ext : corr_ext);
   assign sum_right = 19'(level_right_ff) + (go_back ? corr_ext : -corr_ext);

   always_comb begin
      level_left_in  = level_left_ff;
      level_right_in = level_right_ff;
      base_left_in   = base_left_ff;
      base_right_in  = base_right_ff;
      case (cmd.kind)
         gtdd_pkg::KindStart: begin
            base_left_in   = cmd.base_left;
            base_right_in  = cmd.base_right;
            level_left_in  = $signed({3'b000, cmd.base_left});
            level_right_in = $signed({3'b000, cmd.base_right});
         end
         gtdd_pkg::KindStop: begin
            level_left_in  = '0;
            level_right_in = '0;
         end
         gtdd_pkg::KindTrim: begin
            level_left_in  = clamp_side(sum_left, base_left_ff, cfg);
            level_right_in = clamp_side(sum_right, base_right_ff, cfg);
         end
         default: begin
            level_left_in  = level_left_ff;
            level_right_in = level_right_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_left_ff  <= '0;
         level_right_ff <= '0;
         base_left_ff   <= '0;
         base_right_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            level_left_ff  <= level_left_in;
            level_right_ff <= level_right_in;
            base_left_ff   <= base_left_in;
            base_right_ff  <= base_right_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_left_ff  <= level_left_in[16:0];
         rsp_right_ff <= level_right_in[16:0];
         rsp_dir_ff   <= cmd.mode;
         rsp_corr_ff  <= cmd.correction;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_left  = rsp_left_ff;
   assign rsp_pulse_right = rsp_right_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_correction  = rsp_corr_ff;

`ifndef SYNTHESIS
   a_stop_zeroes: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.kind == gtdd_pkg::KindStop)
      |=> (level_left_ff == '0 && level_right_ff == '0))
      else $error("levels not zero after a stop");

   a_off_no_corr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dir_ff == gtdd_pkg::ModeOff) |-> (rsp_corr_ff == '0))
      else $error("correction reported while the drive is off");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready)
      |=> (rsp_valid_ff
           && $stable({rsp_left_ff, rsp_right_ff, rsp_dir_ff, rsp_corr_ff})))
      else $error("response changed while it waited for a transfer");
`endif

endmodule
`default_nettype wire
